### src/edp_pkg.sv
// ----------------------------------------------------------------------------
// ES descriptor parser package
// Shared widths, protocol constants, result codes and item types.
// ----------------------------------------------------------------------------
package edp_pkg;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned LEN_W   = 28;
  localparam int unsigned TDATA_W = 200;

  // A length field ends after this many bytes whatever its continuation bit
  localparam logic [2:0] LENGTH_BYTES = 3'd4;

  localparam logic [7:0] TAG_ES  = 8'h03;
  localparam logic [7:0] TAG_DEC = 8'h04;
  localparam logic [7:0] TAG_DSI = 8'h05;

  localparam logic [7:0] LEN_DATA_MASK = 8'h7F;
  localparam logic [7:0] LEN_CONT_MASK = 8'h80;

  localparam logic [LEN_W-1:0] ES_LEN_MIN = LEN_W'(20);
  localparam logic [LEN_W-1:0] DC_LEN_MIN = LEN_W'(15);

  typedef enum logic [1:0] {
    KIND_HEADER   = 2'd0,
    KIND_CFG      = 2'd1,
    KIND_CFG_LAST = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SHORT_ES    = 3'd1,
    ST_NO_DEC_TAG  = 3'd2,
    ST_SHORT_DC    = 3'd3,
    ST_NO_DSI_TAG  = 3'd4
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              start_req;
  } in_item_t;

  // Last member sits in the lowest bits, so tdata packs payload_byte first
  typedef struct packed {
    logic [LEN_W-1:0] config_length;
    logic [31:0]      avg_bitrate;
    logic [31:0]      max_bitrate;
    logic [23:0]      buffer_size;
    logic [7:0]       stream_type;
    logic [7:0]       object_type;
    logic [7:0]       priority_res;
    logic [15:0]      es_id;
    logic [31:0]      version_flags;
    status_t          status;
    logic [7:0]       payload_byte;
  } fields_t;

  typedef struct packed {
    kind_t   kind;
    fields_t fields;
  } res_item_t;

  localparam int unsigned FIELDS_W = $bits(fields_t);

endpackage

### src/es_descriptor_parser.sv
// ----------------------------------------------------------------------------
// ES descriptor parser
// Parses an elementary stream descriptor payload byte by byte; emits one
// header record with its status, then, on ST_OK, each decoder configuration byte as its own item.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                      tuser       notes
//  s_*       in   data_byte (8)              start_req   one payload byte/item
//  m_*       out  header fields (200, padded) kind (2)    0..1 item per input
//
//  A byte accepted on s_* waits in the input register while the parse logic
//  builds its result combinationally; the result loads into the result
//  register as the byte leaves the input register, and so appears on m_*.
//  One byte is accepted every cycle while m_tready stays high.
//  A stall on m_* holds the result register, then the input register, then
//  drops s_tready; nothing is lost. Reset leaves the parser idle until a byte
//  with start_req arrives.
// ----------------------------------------------------------------------------
module es_descriptor_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // data_byte[7:0]
  input  logic                        s_tuser,   // start_req
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [edp_pkg::TDATA_W-1:0] m_tdata,   // payload_byte, status, version_flags,
                                                 // es_id, priority_res, object_type,
                                                 // stream_type, buffer_size,
                                                 // max_bitrate, avg_bitrate,
                                                 // config_length, zero pad
  output logic [1:0]                  m_tuser    // kind
);

  logic               in_valid;
  edp_pkg::in_item_t  in_item;
  logic               can_load;
  logic               fire;
  logic               res_valid;
  edp_pkg::res_item_t res;

  assign fire = in_valid && can_load;

  edp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .take     (fire),
    .valid    (in_valid),
    .item     (in_item)
  );

  edp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (in_item),
    .res_valid (res_valid),
    .res       (res)
  );

  edp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (fire && res_valid),
    .res      (res),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

### src/edp_in_stage.sv
// ----------------------------------------------------------------------------
// ES descriptor parser input stage
// Input register for payload bytes; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module edp_in_stage (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [7:0]              s_tdata,   // data_byte[7:0]
  input  logic                    s_tuser,   // start_req
  input  logic                    take,
  output logic                    valid,
  output edp_pkg::in_item_t       item
);

  assign s_tready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.data_byte <= s_tdata;
      item.start_req <= s_tuser;
    end
  end

endmodule

### src/edp_parse.sv
// ----------------------------------------------------------------------------
// ES descriptor parser core
// Byte-serial parse state and header field registers; builds at most one result per byte.
// ----------------------------------------------------------------------------
module edp_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  edp_pkg::in_item_t     item,
  output logic                  res_valid,
  output edp_pkg::res_item_t    res
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_VF, PH_TAG1, PH_ESLEN, PH_ESID, PH_PRIO, PH_SKIP2, PH_TAG2,
    PH_DCLEN, PH_OBJ, PH_STYPE, PH_BUF, PH_MAXBR, PH_AVGBR, PH_TAG3,
    PH_CFGLEN, PH_CFG, PH_DONE
  } phase_t;

  phase_t                     phase, phase_cur, phase_next;
  logic [1:0]                 field_byte_count, fbc_cur, fbc_next;
  logic [edp_pkg::LEN_W-1:0]  length_accum, acc_cur, acc_next;
  logic [2:0]                 length_byte_count, lbc_cur, lbc_next;
  logic [edp_pkg::LEN_W-1:0]  config_remaining, rem_cur, rem_next;
  logic [31:0]                version_flags_reg, vf_cur, vf_next;
  logic [15:0]                es_id_reg, es_cur, es_next;
  logic [7:0]                 priority_reg, prio_cur, prio_next;
  logic [7:0]                 object_type_reg, obj_cur, obj_next;
  logic [7:0]                 stream_type_reg, stype_cur, stype_next;
  logic [23:0]                buffer_size_reg, buf_cur, buf_next;
  logic [31:0]                max_bitrate_reg, maxbr_cur, maxbr_next;
  logic [31:0]                avg_bitrate_reg, avgbr_cur, avgbr_next;

  logic [7:0]                 b;
  logic [2:0]                 fbc_inc;
  logic [edp_pkg::LEN_W-1:0]  len_acc_new;
  logic [2:0]                 len_cnt_new;
  logic                       len_done;
  edp_pkg::fields_t           hdr;

  assign b = item.data_byte;

  always_comb begin
    // A start discards everything gathered and takes this byte as the version
    phase_cur = item.start_req ? PH_VF : phase;
    fbc_cur   = item.start_req ? '0 : field_byte_count;
    acc_cur   = item.start_req ? '0 : length_accum;
    lbc_cur   = item.start_req ? '0 : length_byte_count;
    rem_cur   = item.start_req ? '0 : config_remaining;
    vf_cur    = item.start_req ? '0 : version_flags_reg;
    es_cur    = item.start_req ? '0 : es_id_reg;
    prio_cur  = item.start_req ? '0 : priority_reg;
    obj_cur   = item.start_req ? '0 : object_type_reg;
    stype_cur = item.start_req ? '0 : stream_type_reg;
    buf_cur   = item.start_req ? '0 : buffer_size_reg;
    maxbr_cur = item.start_req ? '0 : max_bitrate_reg;
    avgbr_cur = item.start_req ? '0 : avg_bitrate_reg;

    fbc_inc     = {1'b0, fbc_cur} + 3'd1;
    len_acc_new = {acc_cur[edp_pkg::LEN_W-8:0], b[6:0] & edp_pkg::LEN_DATA_MASK[6:0]};
    len_cnt_new = lbc_cur + 3'd1;
    len_done    = ((b & edp_pkg::LEN_CONT_MASK) == 8'h00) ||
                  (len_cnt_new >= edp_pkg::LENGTH_BYTES);

    hdr               = '0;
    hdr.version_flags = vf_cur;
    hdr.es_id         = es_cur;
    hdr.priority_res  = prio_cur;
    hdr.object_type   = obj_cur;
    hdr.stream_type   = stype_cur;
    hdr.buffer_size   = buf_cur;
    hdr.max_bitrate   = maxbr_cur;
    hdr.avg_bitrate   = avgbr_cur;

    phase_next = phase_cur;
    fbc_next   = fbc_cur;
    acc_next   = acc_cur;
    lbc_next   = lbc_cur;
    rem_next   = rem_cur;
    vf_next    = vf_cur;
    es_next    = es_cur;
    prio_next  = prio_cur;
    obj_next   = obj_cur;
    stype_next = stype_cur;
    buf_next   = buf_cur;
    maxbr_next = maxbr_cur;
    avgbr_next = avgbr_cur;
    res_valid  = 1'b0;
    res        = '0;

    case (phase_cur)
      PH_VF: begin
        vf_next = {vf_cur[23:0], b};
        if (fbc_inc >= 3'd4) begin
          fbc_next   = '0;
          phase_next = PH_TAG1;
        end else begin
          fbc_next = fbc_inc[1:0];
        end
      end
      PH_TAG1: begin
        if (b == edp_pkg::TAG_ES) begin
          acc_next   = '0;
          lbc_next   = '0;
          phase_next = PH_ESLEN;
        end else begin
          phase_next = PH_SKIP2;
        end
      end
      PH_ESLEN: begin
        acc_next = len_acc_new;
        lbc_next = len_cnt_new;
        if (len_done) begin
          if (len_acc_new < edp_pkg::ES_LEN_MIN) begin
            phase_next        = PH_DONE;
            res_valid         = 1'b1;
            res.kind          = edp_pkg::KIND_HEADER;
            res.fields        = hdr;
            res.fields.status = edp_pkg::ST_SHORT_ES;
          end else begin
            phase_next = PH_ESID;
          end
        end
      end
      PH_ESID: begin
        es_next = {es_cur[7:0], b};
        if (fbc_inc >= 3'd2) begin
          fbc_next   = '0;
          phase_next = PH_PRIO;
        end else begin
          fbc_next = fbc_inc[1:0];
        end
      end
      PH_PRIO: begin
        prio_next  = b;
        phase_next = PH_TAG2;
      end
      PH_SKIP2: begin
        if (fbc_inc >= 3'd2) begin
          fbc_next   = '0;
          phase_next = PH_TAG2;
        end else begin
          fbc_next = fbc_inc[1:0];
        end
      end
      PH_TAG2: begin
        if (b != edp_pkg::TAG_DEC) begin
          phase_next        = PH_DONE;
          res_valid         = 1'b1;
          res.kind          = edp_pkg::KIND_HEADER;
          res.fields        = hdr;
          res.fields.status = edp_pkg::ST_NO_DEC_TAG;
        end else begin
          acc_next   = '0;
          lbc_next   = '0;
          phase_next = PH_DCLEN;
        end
      end
      PH_DCLEN: begin
        acc_next = len_acc_new;
        lbc_next = len_cnt_new;
        if (len_done) begin
          if (len_acc_new < edp_pkg::DC_LEN_MIN) begin
            phase_next        = PH_DONE;
            res_valid         = 1'b1;
            res.kind          = edp_pkg::KIND_HEADER;
            res.fields        = hdr;
            res.fields.status = edp_pkg::ST_SHORT_DC;
          end else begin
            phase_next = PH_OBJ;
          end
        end
      end
      PH_OBJ: begin
        obj_next   = b;
        phase_next = PH_STYPE;
      end
      PH_STYPE: begin
        stype_next = b;
        phase_next = PH_BUF;
      end
      PH_BUF: begin
        buf_next = {buf_cur[15:0], b};
        if (fbc_inc >= 3'd3) begin
          fbc_next   = '0;
          phase_next = PH_MAXBR;
        end else begin
          fbc_next = fbc_inc[1:0];
        end
      end
      PH_MAXBR: begin
        maxbr_next = {maxbr_cur[23:0], b};
        if (fbc_inc >= 3'd4) begin
          fbc_next   = '0;
          phase_next = PH_AVGBR;
        end else begin
          fbc_next = fbc_inc[1:0];
        end
      end
      PH_AVGBR: begin
        avgbr_next = {avgbr_cur[23:0], b};
        if (fbc_inc >= 3'd4) begin
          fbc_next   = '0;
          phase_next = PH_TAG3;
        end else begin
          fbc_next = fbc_inc[1:0];
        end
      end
      PH_TAG3: begin
        if (b != edp_pkg::TAG_DSI) begin
          phase_next        = PH_DONE;
          res_valid         = 1'b1;
          res.kind          = edp_pkg::KIND_HEADER;
          res.fields        = hdr;
          res.fields.status = edp_pkg::ST_NO_DSI_TAG;
        end else begin
          acc_next   = '0;
          lbc_next   = '0;
          phase_next = PH_CFGLEN;
        end
      end
      PH_CFGLEN: begin
        acc_next = len_acc_new;
        lbc_next = len_cnt_new;
        if (len_done) begin
          rem_next   = len_acc_new;
          phase_next = (len_acc_new == '0) ? PH_DONE : PH_CFG;
          res_valid  = 1'b1;
          res.kind   = edp_pkg::KIND_HEADER;
          res.fields = hdr;
          res.fields.status        = edp_pkg::ST_OK;
          res.fields.config_length = len_acc_new;
        end
      end
      PH_CFG: begin
        res_valid               = 1'b1;
        res.fields.payload_byte = b;
        if (rem_cur <= edp_pkg::LEN_W'(1)) begin
          rem_next   = '0;
          phase_next = PH_DONE;
          res.kind   = edp_pkg::KIND_CFG_LAST;
        end else begin
          rem_next = rem_cur - edp_pkg::LEN_W'(1);
          res.kind = edp_pkg::KIND_CFG;
        end
      end
      default: begin
        // idle or finished: drop the byte
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      field_byte_count  <= '0;
      length_accum      <= '0;
      length_byte_count <= '0;
      config_remaining  <= '0;
      version_flags_reg <= '0;
      es_id_reg         <= '0;
      priority_reg      <= '0;
      object_type_reg   <= '0;
      stream_type_reg   <= '0;
      buffer_size_reg   <= '0;
      max_bitrate_reg   <= '0;
      avg_bitrate_reg   <= '0;
    end else if (fire) begin
      phase             <= phase_next;
      field_byte_count  <= fbc_next;
      length_accum      <= acc_next;
      length_byte_count <= lbc_next;
      config_remaining  <= rem_next;
      version_flags_reg <= vf_next;
      es_id_reg         <= es_next;
      priority_reg      <= prio_next;
      object_type_reg   <= obj_next;
      stream_type_reg   <= stype_next;
      buffer_size_reg   <= buf_next;
      max_bitrate_reg   <= maxbr_next;
      avg_bitrate_reg   <= avgbr_next;
    end
  end

endmodule

### src/edp_out_reg.sv
// ----------------------------------------------------------------------------
// ES descriptor parser output register
// Result register on the master side; loads while the previous item leaves.
// ----------------------------------------------------------------------------
module edp_out_reg (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  edp_pkg::res_item_t      res,
  output logic                    can_load,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [edp_pkg::TDATA_W-1:0] m_tdata,  // payload_byte[7:0], status[10:8],
                                                // version_flags[42:11], es_id[58:43],
                                                // priority_res[66:59],
                                                // object_type[74:67],
                                                // stream_type[82:75],
                                                // buffer_size[106:83],
                                                // max_bitrate[138:107],
                                                // avg_bitrate[170:139],
                                                // config_length[198:171], zero pad
  output logic [1:0]              m_tuser       // kind[1:0]
);

  edp_pkg::res_item_t res_q;

  assign can_load = !m_tvalid || m_tready;
  assign m_tdata  = {{(edp_pkg::TDATA_W - edp_pkg::FIELDS_W){1'b0}}, res_q.fields};
  assign m_tuser  = res_q.kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

endmodule
